FILE: src/ddf_pkg.sv
// ddf_pkg: shared types and constants for the decimal display formatter
// used by ddf_bcd, ddf_emit and decimal_display_formatter; no dependencies
package ddf_pkg;

  localparam int DIGITS = 10;
  localparam int PW     = 7;

  localparam logic [3:0] CODE_MINUS = 4'd10;
  localparam logic [3:0] CODE_BLANK = 4'd11;

  localparam logic [1:0] REG_SECTION_SIZE   = 2'd0;
  localparam logic [1:0] REG_ALIGNMENT      = 2'd1;
  localparam logic [1:0] REG_LEADING_ZEROS  = 2'd2;
  localparam logic [1:0] REG_DECIMAL_PLACES = 2'd3;

  localparam logic [1:0] PLACE_LEFT   = 2'd0;
  localparam logic [1:0] PLACE_RIGHT  = 2'd1;
  localparam logic [1:0] PLACE_CENTRE = 2'd2;

  typedef logic [DIGITS-1:0][3:0] digits_t;
  typedef logic signed [PW-1:0] pos_t;

  typedef struct packed {
    logic [3:0] section_size;
    logic [1:0] alignment;
    logic       leading_zeros;
    logic [2:0] decimal_places;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

FILE: src/ddf_bcd.sv
// ddf_bcd: iterative binary to bcd converter, one shift-and-add-3 step per cycle
// depends on ddf_pkg
module ddf_bcd (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [31:0]         mag,
  output ddf_pkg::digits_t    digits,
  output ddf_pkg::unit_stat_t stat
);

  typedef enum logic {B_IDLE, B_RUN} bstate_t;

  bstate_t          bstate;
  logic [4:0]       count;
  logic [31:0]      bin;
  ddf_pkg::digits_t bcd;
  ddf_pkg::digits_t adj;
  logic [39:0]      adj_flat;
  logic             done;
  logic             digits_ok;

  // add 3 to every digit of five or more before the shift
  always_comb begin
    for (int k = 0; k < ddf_pkg::DIGITS; k++) begin
      adj[k] = (bcd[k] >= 4'd5) ? bcd[k] + 4'd3 : bcd[k];
    end
  end

  assign adj_flat = adj;

  always_ff @(posedge clk) begin
    if (rst) begin
      bstate <= B_IDLE;
      done   <= 1'b0;
      count  <= '0;
    end else begin
      case (bstate)
        B_IDLE: begin
          done <= 1'b0;
          if (start) begin
            bin    <= mag;
            bcd    <= '0;
            count  <= '0;
            bstate <= B_RUN;
          end
        end
        B_RUN: begin
          bcd   <= {adj_flat[38:0], bin[31]};
          bin   <= {bin[30:0], 1'b0};
          count <= count + 5'd1;
          done  <= (count == 5'd31);
          if (count == 5'd31) begin
            bstate <= B_IDLE;
          end
        end
        default: begin
          done   <= 1'b0;
          bstate <= B_IDLE;
        end
      endcase
    end
  end

  assign digits    = bcd;
  assign stat.busy = (bstate == B_RUN);
  assign stat.done = done;

  always_comb begin
    digits_ok = 1'b1;
    for (int k = 0; k < ddf_pkg::DIGITS; k++) begin
      if (bcd[k] > 4'd9) digits_ok = 1'b0;
    end
  end

  a_digits_decimal: assert property (@(posedge clk) disable iff (rst) done |-> digits_ok)
    else $error("bcd digit above nine at end of conversion");

endmodule

FILE: src/ddf_emit.sv
// ddf_emit: works out text placement, then emits one character word per position
// depends on ddf_pkg; digits come from ddf_bcd
module ddf_emit #(
  parameter int MAX_POSITIONS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                neg,
  input  ddf_pkg::digits_t    digits,
  input  ddf_pkg::cfg_t       cfg,
  output ddf_pkg::unit_stat_t stat,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          position,
  output logic [3:0]          char_code,
  output logic                dot_on,
  output logic                last
);

  localparam int SW = $clog2(MAX_POSITIONS + 1);

  typedef enum logic [1:0] {E_IDLE, E_SETUP, E_RUN} estate_t;

  estate_t       estate;
  logic          done;
  logic [SW-1:0] size_c;
  logic [SW-1:0] size_r;
  logic [SW-1:0] idx;
  logic [3:0]    ndig;
  logic [3:0]    dp1;
  logic [3:0]    core;
  ddf_pkg::pos_t width_s, size_s, diff, half, left_c, right_c, dot_c;
  ddf_pkg::pos_t left_r, right_r, dot_r, i_s, rel;
  logic          dot_ok_c, dot_ok_r;
  logic [3:0]    code;
  logic          load;
  logic          is_last;

  // section size saturates at the number of positions built
  assign size_c = ({1'b0, cfg.section_size} > 5'(MAX_POSITIONS)) ? SW'(MAX_POSITIONS)
                                                                 : SW'(cfg.section_size);

  // text geometry
  always_comb begin
    ndig = 4'd1;
    for (int k = 0; k < ddf_pkg::DIGITS; k++) begin
      if (digits[k] != 4'd0) ndig = 4'(k + 1);
    end
    dp1     = {1'b0, cfg.decimal_places} + 4'd1;
    core    = (ndig > dp1) ? ndig : dp1;
    width_s = ddf_pkg::pos_t'({3'b000, core}) + ddf_pkg::pos_t'({6'd0, neg});
    size_s  = ddf_pkg::pos_t'({{(ddf_pkg::PW - SW){1'b0}}, size_c});
    diff    = size_s - width_s;
    // halve with truncation toward zero
    half    = (diff + ddf_pkg::pos_t'({6'd0, diff[ddf_pkg::PW-1]})) >>> 1;
    case (cfg.alignment)
      ddf_pkg::PLACE_LEFT:  left_c = '0;
      ddf_pkg::PLACE_RIGHT: left_c = diff;
      default:              left_c = half;
    endcase
    right_c  = left_c + width_s - ddf_pkg::pos_t'(7'd1);
    dot_c    = right_c - ddf_pkg::pos_t'({4'd0, cfg.decimal_places});
    dot_ok_c = (cfg.decimal_places != 3'd0) && !dot_c[ddf_pkg::PW-1] && (dot_c < size_s);
  end

  // character at the current position
  always_comb begin
    i_s = ddf_pkg::pos_t'({{(ddf_pkg::PW - SW){1'b0}}, idx});
    rel = right_r - i_s;
    if (i_s < left_r) begin
      code = cfg.leading_zeros ? 4'd0 : ddf_pkg::CODE_BLANK;
    end else if (i_s <= right_r) begin
      if (neg && (i_s == left_r)) begin
        code = ddf_pkg::CODE_MINUS;
      end else if (rel < ddf_pkg::pos_t'(7'd10)) begin
        code = digits[rel[3:0]];
      end else begin
        code = 4'd0;
      end
    end else begin
      code = ddf_pkg::CODE_BLANK;
    end
  end

  assign load    = (estate == E_RUN) && (!out_valid || out_ready);
  assign is_last = (idx == SW'(size_r - 1'b1));

  always_ff @(posedge clk) begin
    if (rst) begin
      estate    <= E_IDLE;
      done      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // while running, the word register refills whenever it is empty or being taken
      out_valid <= load || (out_valid && !out_ready);
      case (estate)
        E_IDLE: begin
          done <= 1'b0;
          if (start) estate <= E_SETUP;
        end
        E_SETUP: begin
          size_r   <= size_c;
          left_r   <= left_c;
          right_r  <= right_c;
          dot_r    <= dot_c;
          dot_ok_r <= dot_ok_c;
          idx      <= '0;
          done     <= (size_c == '0);
          if (size_c == '0) begin
            estate <= E_IDLE;
          end else begin
            estate <= E_RUN;
          end
        end
        E_RUN: begin
          done <= load && is_last;
          if (load) begin
            position  <= i_s[2:0];
            char_code <= code;
            dot_on    <= dot_ok_r && (i_s == dot_r);
            last      <= is_last;
            idx       <= idx + 1'b1;
            if (is_last) begin
              estate <= E_IDLE;
            end
          end
        end
        default: begin
          done   <= 1'b0;
          estate <= E_IDLE;
        end
      endcase
    end
  end

  assign stat.busy = (estate != E_IDLE);
  assign stat.done = done;

  a_dot_on_digit: assert property (@(posedge clk) disable iff (rst)
      out_valid && dot_on |-> (char_code != ddf_pkg::CODE_MINUS) &&
                              (char_code != ddf_pkg::CODE_BLANK))
    else $error("dot lit on a sign or blank position");

  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
      load && is_last |=> (estate == E_IDLE) && out_valid && last && done)
    else $error("final position did not end the run");

endmodule

FILE: src/decimal_display_formatter.sv
// decimal_display_formatter: top level with config registers and item sequencer
// depends on ddf_pkg, ddf_bcd and ddf_emit
//
//  channel  signals                                     width  dir
//  cfg      cfg_valid cfg_ready cfg_index cfg_data       2/4    in
//  in       in_valid in_ready value                      32     in
//  out      out_valid out_ready position char_code       3/4/1  out
//           dot_on last
//
// an item runs through the 32 steps of the shift-and-add-3 converter, then
// the setup step, then emits one word per section position
// a zero section size emits no word and ends after the setup cycle
// reset restores section size 8, left alignment, blank fill, no decimals
// a stalled out word holds in its register; in_ready stays low until the
// last word of the item has been loaded into that register
module decimal_display_formatter #(
  parameter int MAX_POSITIONS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [3:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         position,
  output logic [3:0]         char_code,
  output logic               dot_on,
  output logic               last
);

  typedef enum logic [1:0] {S_IDLE, S_CONV, S_FMT} state_t;

  state_t              state;
  ddf_pkg::cfg_t       cfg;
  logic                neg;
  logic [31:0]         mag;
  logic                accept;
  logic                emit_start;
  ddf_pkg::digits_t    digits;
  ddf_pkg::unit_stat_t bcd_stat;
  ddf_pkg::unit_stat_t emit_stat;

  assign cfg_ready  = 1'b1;
  assign in_ready   = (state == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign mag        = value[31] ? (32'd0 - value) : value;
  assign emit_start = (state == S_CONV) && bcd_stat.done;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.section_size   <= 4'd8;
      cfg.alignment      <= ddf_pkg::PLACE_LEFT;
      cfg.leading_zeros  <= 1'b0;
      cfg.decimal_places <= 3'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ddf_pkg::REG_SECTION_SIZE:   cfg.section_size   <= cfg_data;
        ddf_pkg::REG_ALIGNMENT:      cfg.alignment      <= cfg_data[1:0];
        ddf_pkg::REG_LEADING_ZEROS:  cfg.leading_zeros  <= cfg_data[0];
        ddf_pkg::REG_DECIMAL_PLACES: cfg.decimal_places <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            neg   <= value[31];
            state <= S_CONV;
          end
        end
        S_CONV: begin
          if (bcd_stat.done) state <= S_FMT;
        end
        S_FMT: begin
          if (emit_stat.done) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  ddf_bcd u_bcd (
    .clk    (clk),
    .rst    (rst),
    .start  (accept),
    .mag    (mag),
    .digits (digits),
    .stat   (bcd_stat)
  );

  ddf_emit #(
    .MAX_POSITIONS (MAX_POSITIONS)
  ) u_emit (
    .clk       (clk),
    .rst       (rst),
    .start     (emit_start),
    .neg       (neg),
    .digits    (digits),
    .cfg       (cfg),
    .stat      (emit_stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .position  (position),
    .char_code (char_code),
    .dot_on    (dot_on),
    .last      (last)
  );

  a_accept_starts_conv: assert property (@(posedge clk) disable iff (rst)
      accept |=> bcd_stat.busy && (state == S_CONV))
    else $error("accepted word did not start conversion");

  a_conv_done_in_conv: assert property (@(posedge clk) disable iff (rst)
      bcd_stat.done |-> (state == S_CONV) && !emit_stat.busy)
    else $error("conversion finished outside the conversion phase");

endmodule

FILE: sim/tb.sv
// tb: self-checking bench for decimal_display_formatter, run on its own
// depends on ddf_pkg and the formatter rtl; predicts every display word in place
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_POSITIONS = 8;
  localparam int SETTLE_CYCLES = 100;
  localparam logic [1:0] PLACE_ALT_CENTRE = 2'd3;
  localparam logic signed [4:0] NO_DOT = -5'sd1;

  typedef struct packed {
    logic [2:0] pos;
    logic [3:0] code;
    logic       dot;
    logic       lst;
  } glyph_t;

  typedef struct packed {
    logic [3:0]        sz;
    logic [1:0]        al;
    logic              lz;
    logic [2:0]        dp;
    logic [31:0]       v;
    logic              typed;
    logic [63:0]       txt;
    logic signed [4:0] dot_at;
  } digit_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = ddf_pkg::REG_SECTION_SIZE;
  logic [3:0]         cfg_data = 4'd0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] value = 32'sd0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [2:0]         position;
  logic [3:0]         char_code;
  logic               dot_on;
  logic               last;

  // register copies as the block holds them
  logic [3:0] cur_size = 4'd8;
  logic [1:0] cur_align = ddf_pkg::PLACE_LEFT;
  logic       cur_lz = 1'b0;
  logic [2:0] cur_dp = 3'd0;

  glyph_t pending_words[$];
  glyph_t seen_word, due_word;
  int     fails = 0;
  int     send_idle_pct = 0;
  int     stall_pct = 0;

  decimal_display_formatter #(.MAX_POSITIONS(MAX_POSITIONS)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .position  (position),
    .char_code (char_code),
    .dot_on    (dot_on),
    .last      (last)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // directed rows; txt is the section read left to right, padded to eight
  digit_row_t rows[24] = '{
    '{4'd8, ddf_pkg::PLACE_LEFT, 1'b0, 3'd0, 32'd0, 1'b1, "0       ", NO_DOT},
    '{4'd8, ddf_pkg::PLACE_LEFT, 1'b0, 3'd0, 32'h7FFF_FFFF, 1'b1, "21474836", NO_DOT},
    '{4'd8, ddf_pkg::PLACE_LEFT, 1'b0, 3'd0, 32'h8000_0000, 1'b1, "-2147483", NO_DOT},
    '{4'd8, ddf_pkg::PLACE_LEFT, 1'b0, 3'd0, -32'sd1, 1'b1, "-1      ", NO_DOT},
    '{4'd8, ddf_pkg::PLACE_RIGHT, 1'b1, 3'd0, -32'sd42, 1'b1, "00000-42", NO_DOT},
    '{4'd8, ddf_pkg::PLACE_RIGHT, 1'b0, 3'd2, 32'd12345, 1'b1, "   12345", 5'sd5},
    '{4'd8, ddf_pkg::PLACE_RIGHT, 1'b0, 3'd7, 32'd5, 1'b1, "00000005", 5'sd0},
    '{4'd8, ddf_pkg::PLACE_RIGHT, 1'b0, 3'd7, -32'sd5, 1'b1, "00000005", 5'sd0},
    '{4'd8, ddf_pkg::PLACE_LEFT, 1'b1, 3'd3, 32'd7, 1'b1, "0007    ", 5'sd0},
    '{4'd8, ddf_pkg::PLACE_LEFT, 1'b0, 3'd7, 32'h8000_0000, 1'b1, "-2147483", 5'sd3},
    '{4'd4, ddf_pkg::PLACE_CENTRE, 1'b0, 3'd0, 32'd7, 1'b1, " 7      ", NO_DOT},
    '{4'd4, ddf_pkg::PLACE_CENTRE, 1'b0, 3'd0, 32'd123456, 1'b1, "2345    ", NO_DOT},
    '{4'd4, ddf_pkg::PLACE_CENTRE, 1'b0, 3'd0, -32'sd123456, 1'b1, "1234    ", NO_DOT},
    '{4'd1, ddf_pkg::PLACE_RIGHT, 1'b0, 3'd1, 32'd98, 1'b1, "8       ", NO_DOT},
    '{4'd0, ddf_pkg::PLACE_RIGHT, 1'b0, 3'd1, 32'd1234, 1'b1, "        ", NO_DOT},
    '{4'd15, PLACE_ALT_CENTRE, 1'b1, 3'd0, 32'd99, 1'b1, "00099   ", NO_DOT},
    '{4'd8, ddf_pkg::PLACE_CENTRE, 1'b1, 3'd4, -32'sd31416, 1'b1, "0-31416 ", 5'sd2},
    '{4'd6, ddf_pkg::PLACE_RIGHT, 1'b1, 3'd2, 32'd3, 1'b1, "000003  ", 5'sd3},
    '{4'd7, ddf_pkg::PLACE_LEFT, 1'b1, 3'd5, 32'd1000000, 1'b0, "        ", NO_DOT},
    '{4'd3, ddf_pkg::PLACE_RIGHT, 1'b0, 3'd6, -32'sd987654321, 1'b0, "        ", NO_DOT},
    '{4'd8, ddf_pkg::PLACE_CENTRE, 1'b0, 3'd1, 32'hFFFF_FFFF, 1'b0, "        ", NO_DOT},
    '{4'd2, ddf_pkg::PLACE_LEFT, 1'b1, 3'd2, 32'd1000000000, 1'b0, "        ", NO_DOT},
    '{4'd9, ddf_pkg::PLACE_RIGHT, 1'b0, 3'd0, -32'sd2147483647, 1'b0, "        ", NO_DOT},
    '{4'd8, ddf_pkg::PLACE_LEFT, 1'b0, 3'd0, 32'h5555_5555, 1'b0, "        ", NO_DOT}
  };

  function automatic void push_word(input int i, input logic [3:0] code,
                                    input int dot_at, input int size);
    pending_words.push_back('{3'(i), code, i == dot_at, i == size - 1});
  endfunction

  function automatic int shown_size();
    return (cur_size > MAX_POSITIONS) ? MAX_POSITIONS : int'(cur_size);
  endfunction

  function automatic void push_text(input logic [63:0] txt, input int dot_at);
    int size, i;
    logic [7:0] ch;
    logic [3:0] code;
    size = shown_size();
    for (i = 0; i < size; i++) begin
      ch = txt[63 - 8*i -: 8];
      if (ch == "-") code = ddf_pkg::CODE_MINUS;
      else if (ch == " ") code = ddf_pkg::CODE_BLANK;
      else code = 4'(ch - "0");
      push_word(i, code, dot_at, size);
    end
  endfunction

  // expected words for one value under the current register copies
  function automatic void format_number(input logic [31:0] raw);
    logic [31:0] mag;
    logic [3:0]  dig [10];
    logic [3:0]  txt [11];
    logic [3:0]  code;
    logic        neg;
    int ndig, core, width, size, lo, hi, dot_at, dp_n, k;
    neg = raw[31];
    mag = neg ? (32'd0 - raw) : raw;
    dp_n = cur_dp;
    ndig = 1;
    for (k = 0; k < 10; k++) begin
      dig[k] = 4'(mag % 10);
      mag = mag / 10;
      if (dig[k] != 4'd0) ndig = k + 1;
    end
    core = (dp_n + 1 > ndig) ? dp_n + 1 : ndig;
    width = core + (neg ? 1 : 0);
    for (k = 0; k < width; k++)
      txt[k] = (neg && k == 0) ? ddf_pkg::CODE_MINUS : dig[width - 1 - k];
    size = shown_size();
    if (size == 0) return;
    case (cur_align)
      ddf_pkg::PLACE_LEFT:  lo = 0;
      ddf_pkg::PLACE_RIGHT: lo = size - width;
      default:              lo = (size - width) / 2;
    endcase
    hi = lo + width - 1;
    dot_at = -1;
    if (dp_n != 0) begin
      dot_at = hi - dp_n;
      if (dot_at < 0 || dot_at >= size) dot_at = -1;
    end
    for (k = 0; k < size; k++) begin
      if (k < lo) code = cur_lz ? 4'd0 : ddf_pkg::CODE_BLANK;
      else if (k <= hi) code = txt[k - lo];
      else code = ddf_pkg::CODE_BLANK;
      push_word(k, code, dot_at, size);
    end
  endfunction

  // let every outstanding word drain, then give a zero-size item time to finish
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(input logic [3:0] sz_d, input logic [3:0] al_d,
                              input logic [3:0] lz_d, input logic [3:0] dp_d);
    logic [1:0] reg_idx [4];
    logic [3:0] wdata [4];
    int k;
    reg_idx[0] = ddf_pkg::REG_SECTION_SIZE;
    reg_idx[1] = ddf_pkg::REG_ALIGNMENT;
    reg_idx[2] = ddf_pkg::REG_LEADING_ZEROS;
    reg_idx[3] = ddf_pkg::REG_DECIMAL_PLACES;
    wdata[0] = sz_d;
    wdata[1] = al_d;
    wdata[2] = lz_d;
    wdata[3] = dp_d;
    drain();
    for (k = 0; k < 4; k++) begin
      @(negedge clk);
      cfg_valid <= 1'b1;
      cfg_index <= reg_idx[k];
      cfg_data <= wdata[k];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cur_size = sz_d;
    cur_align = al_d[1:0];
    cur_lz = lz_d[0];
    cur_dp = dp_d[2:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // returns at the edge where the word is taken; valid stays up until the next call or drain
  task automatic send_value(input logic [31:0] v);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  always @(negedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      seen_word = '{position, char_code, dot_on, last};
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word pos %0d code %0d dot %0b last %0b", $time,
                 position, char_code, dot_on, last);
        fails++;
      end else begin
        due_word = pending_words.pop_front();
        if (seen_word !== due_word) begin
          $display("%0t: expected pos %0d code %0d dot %0b last %0b, got %0d %0d %0b %0b",
                   $time, due_word.pos, due_word.code, due_word.dot, due_word.lst,
                   position, char_code, dot_on, last);
          fails++;
        end
      end
    end
  end

  initial begin
    digit_row_t row;
    logic [31:0] v;
    logic [3:0]  sz;
    int r, ph, n, lim;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    for (r = 0; r < 24; r++) begin
      row = rows[r];
      if ({row.sz, row.al, row.lz, row.dp} != {cur_size, cur_align, cur_lz, cur_dp})
        write_config(row.sz, {2'b00, row.al}, {3'b000, row.lz}, {1'b0, row.dp});
      send_value(row.v);
      if (row.typed) push_text(row.txt, row.dot_at);
      else format_number(row.v);
    end

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 64; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 64; end
        default: begin send_idle_pct = 29; stall_pct = 29; end
      endcase
      for (n = 0; n < 38; n++) begin
        if (n % 10 == 0) begin
          r = $urandom_range(19);
          if (r == 0) sz = 4'd0;
          else if (r == 1) sz = 4'($urandom_range(15, 9));
          else if (r < 6) sz = 4'd8;
          else sz = 4'($urandom_range(8, 1));
          // upper data bits beyond each field are noise the block must mask
          write_config(sz, 4'($urandom_range(15)), 4'($urandom_range(15)),
                       4'($urandom_range(15)));
        end
        case ($urandom_range(7))
          0: v = $urandom();
          1: v = 32'($urandom_range(9));
          2: v = ($urandom_range(1) != 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
          default: begin
            lim = $urandom_range(9, 1);
            v = 32'd1;
            repeat (lim) v = v * 10;
            v = $urandom_range(v - 1);
            if ($urandom_range(1) != 0) v = 32'd0 - v;
          end
        endcase
        send_value(v);
        format_number(v);
      end
    end

    drain();
    if (fails == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
